### hdl/acss_pkg.sv
// Shared types and constants for the actuation safety supervisor.
package acss_pkg;

    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned FIELD_TIME_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ARMED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKOUT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRACE = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_TTL = 2'd3;

    localparam logic [FIELD_TIME_BITS-1:0] RST_LOCKOUT_MS = 32'd10000;
    localparam logic [FIELD_TIME_BITS-1:0] RST_GRACE_MS = 32'd750;
    localparam logic [FIELD_TIME_BITS-1:0] RST_DEFAULT_TTL_MS = 32'd500;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_PERMIT = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

    localparam logic [1:0] DENY_NONE = 2'd0;
    localparam logic [1:0] DENY_NOT_ARMED = 2'd1;
    localparam logic [1:0] DENY_LOCKOUT = 2'd2;
    localparam logic [1:0] DENY_CLASS_SWITCH = 2'd3;

    localparam logic [2:0] CLASS_GATE = 3'd3;

    typedef struct packed {
        logic                       armed;
        logic [FIELD_TIME_BITS-1:0] lockout_ms;
        logic [FIELD_TIME_BITS-1:0] grace_ms;
        logic [FIELD_TIME_BITS-1:0] default_ttl_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [FIELD_TIME_BITS-1:0] now_ms;
        logic                       override_active;
        logic                       c3_enable;
        logic [2:0]                 action_class;
        logic [FIELD_TIME_BITS-1:0] ttl_ms;
        logic [FIELD_TIME_BITS-1:0] hard_cap_ms;
    } t_item;

    typedef struct packed {
        logic       release_outputs;
        logic       override_event;
        logic       link_release_event;
        logic       granted;
        logic [1:0] deny_reason;
    } t_result;

endpackage

### hdl/acss_cfg.sv
// Configuration register file of the actuation safety supervisor.
module acss_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [acss_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [acss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output acss_pkg::t_cfg                      o_cfg
);

    acss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.armed          <= 1'b0;
            r_cfg.lockout_ms     <= acss_pkg::RST_LOCKOUT_MS;
            r_cfg.grace_ms       <= acss_pkg::RST_GRACE_MS;
            r_cfg.default_ttl_ms <= acss_pkg::RST_DEFAULT_TTL_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                acss_pkg::REG_ARMED:       r_cfg.armed          <= i_cfg_data[0];
                acss_pkg::REG_LOCKOUT:     r_cfg.lockout_ms     <= i_cfg_data;
                acss_pkg::REG_GRACE:       r_cfg.grace_ms       <= i_cfg_data;
                acss_pkg::REG_DEFAULT_TTL: r_cfg.default_ttl_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/acss_core.sv
// Supervisor state and the combinational decision logic for one event.
module acss_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  acss_pkg::t_item   i_item,
    input  acss_pkg::t_cfg    i_cfg,
    output acss_pkg::t_result o_result
);

    logic [TIME_BITS-1:0] r_heartbeat;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_ttl;
    logic [TIME_BITS-1:0] r_cap;
    logic [TIME_BITS-1:0] r_until;
    logic                 r_c3_closed;

    logic [TIME_BITS-1:0] n_heartbeat;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] n_ttl;
    logic [TIME_BITS-1:0] n_cap;
    logic [TIME_BITS-1:0] n_until;
    logic                 n_c3_closed;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_req_ttl;
    logic [TIME_BITS-1:0] w_req_cap;
    logic [TIME_BITS-1:0] w_lockout;
    logic [TIME_BITS-1:0] w_grace;
    logic [TIME_BITS-1:0] w_dflt_ttl;
    logic [TIME_BITS-1:0] w_run;
    logic [TIME_BITS-1:0] w_silence;
    logic                 w_stale;
    logic                 w_expired;
    logic                 w_capped;
    acss_pkg::t_result    w_result;

    assign w_now      = TIME_BITS'(i_item.now_ms);
    assign w_req_ttl  = TIME_BITS'(i_item.ttl_ms);
    assign w_req_cap  = TIME_BITS'(i_item.hard_cap_ms);
    assign w_lockout  = TIME_BITS'(i_cfg.lockout_ms);
    assign w_grace    = TIME_BITS'(i_cfg.grace_ms);
    assign w_dflt_ttl = TIME_BITS'(i_cfg.default_ttl_ms);

    assign w_run     = w_now - r_start;
    assign w_silence = w_now - r_heartbeat;
    assign w_stale   = w_silence > w_grace;
    assign w_expired = (r_ttl != '0) && (w_run > r_ttl);
    assign w_capped  = (r_cap != '0) && (w_run > r_cap);

    always_comb begin
        n_heartbeat = r_heartbeat;
        n_start     = r_start;
        n_ttl       = r_ttl;
        n_cap       = r_cap;
        n_until     = r_until;
        n_c3_closed = r_c3_closed;
        w_result    = '0;
        unique case (i_item.kind)
            acss_pkg::KIND_TICK: begin
                if (i_item.override_active) begin
                    n_until = w_now + w_lockout;
                end
                n_c3_closed = i_item.c3_enable;
                if (w_stale || w_expired || w_capped) begin
                    n_ttl = '0;
                end
                w_result.override_event     = i_item.override_active;
                w_result.link_release_event = w_stale;
                w_result.release_outputs    = i_item.override_active || w_stale
                                              || w_expired || w_capped;
            end
            acss_pkg::KIND_PERMIT: begin
                if (!i_cfg.armed) begin
                    w_result.deny_reason = acss_pkg::DENY_NOT_ARMED;
                end else if (w_now < r_until) begin
                    w_result.deny_reason = acss_pkg::DENY_LOCKOUT;
                end else if ((i_item.action_class >= acss_pkg::CLASS_GATE) && !r_c3_closed) begin
                    w_result.deny_reason = acss_pkg::DENY_CLASS_SWITCH;
                end else begin
                    n_start          = w_now;
                    n_ttl            = (w_req_ttl != '0) ? w_req_ttl : w_dflt_ttl;
                    n_cap            = w_req_cap;
                    w_result.granted = 1'b1;
                end
            end
            acss_pkg::KIND_HEARTBEAT: begin
                n_heartbeat = w_now;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heartbeat <= '0;
            r_start     <= '0;
            r_ttl       <= '0;
            r_cap       <= '0;
            r_until     <= '0;
            r_c3_closed <= 1'b0;
        end else if (i_step) begin
            r_heartbeat <= n_heartbeat;
            r_start     <= n_start;
            r_ttl       <= n_ttl;
            r_cap       <= n_cap;
            r_until     <= n_until;
            r_c3_closed <= n_c3_closed;
        end
    end

    assign o_result = w_result;

endmodule

### hdl/actuation_safety_supervisor_unit.sv
// Top level of the actuation safety supervisor: input stage, result stage, wiring.
//
//  Channel  | Handshake          | Beat contents
//  ---------+--------------------+------------------------------------------------
//  event in | i_valid / o_ready  | kind, now_ms, override, c3 enable, class, ttl, cap
//  result   | o_valid / i_ready  | release, override, link release, granted, deny
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data (write only)
//
// One event is accepted every cycle while the result side does not stall.
// Each event waits in the input stage; its result is registered as the state updates.
// Active-low synchronous reset clears valids and state and sets config reset values.
// A stall on the result side fills the input stage, then drops o_ready.
module actuation_safety_supervisor_unit #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic        i_override_active,
    input  logic        i_c3_enable,
    input  logic [2:0]  i_action_class,
    input  logic [31:0] i_ttl_ms,
    input  logic [31:0] i_hard_cap_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_release_outputs,
    output logic        o_override_event,
    output logic        o_link_release_event,
    output logic        o_granted,
    output logic [1:0]  o_deny_reason,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    acss_pkg::t_cfg    w_cfg;
    acss_pkg::t_item   r_item;
    acss_pkg::t_result r_result;
    acss_pkg::t_result w_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_step;
    logic              w_take;

    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;
    assign w_take  = i_valid && o_ready;

    acss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    acss_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind            <= i_kind;
            r_item.now_ms          <= i_now_ms;
            r_item.override_active <= i_override_active;
            r_item.c3_enable       <= i_c3_enable;
            r_item.action_class    <= i_action_class;
            r_item.ttl_ms          <= i_ttl_ms;
            r_item.hard_cap_ms     <= i_hard_cap_ms;
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_release_outputs    = r_result.release_outputs;
    assign o_override_event     = r_result.override_event;
    assign o_link_release_event = r_result.link_release_event;
    assign o_granted            = r_result.granted;
    assign o_deny_reason        = r_result.deny_reason;

    a_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_deny_reason == acss_pkg::DENY_NONE
                                    && !o_release_outputs))
        else $error("Granted beat carries a deny reason or a release.");

    a_link_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_link_release_event) |-> o_release_outputs)
        else $error("Link release beat without release.");

    a_override_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_override_event) |-> o_release_outputs)
        else $error("Override beat without release.");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> (r_in_valid && r_out_valid))
        else $error("Pipeline dropped a beat while stalled.");

endmodule
